>>> design/periodic_publish_with_limit_alarm_assert.svh
// Assertion macros shared by the periodic publisher modules.
// No dependencies; each macro expands to nothing when SYNTHESIS is defined.
`ifndef PERIODIC_PUBLISH_WITH_LIMIT_ALARM_ASSERT_SVH
`define PERIODIC_PUBLISH_WITH_LIMIT_ALARM_ASSERT_SVH
`ifndef SYNTHESIS
`define PPLA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ppla assertion failed");
`define PPLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppla assertion failed");
`else
`define PPLA_ASSERT(label, clk, rst, prop)
`define PPLA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/ppla_pkg.sv
// Types and constants of the periodic publisher with limit alarm.
// Used by every module of the block; depends on nothing.
package ppla_pkg;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_RECV = 2'd2;

   localparam logic [1:0] KIND_PUB   = 2'd0;
   localparam logic [1:0] KIND_LOOP  = 2'd1;
   localparam logic [1:0] KIND_ALARM = 2'd2;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_ID     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPTIONS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_MSG_ID = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_MSG_ID = 3'd7;

   localparam int unsigned OPT_PUB   = 0;
   localparam int unsigned OPT_LOOP  = 1;
   localparam int unsigned OPT_MIN   = 2;
   localparam int unsigned OPT_MAX   = 3;
   localparam int unsigned OPT_EVENT = 4;
   localparam logic [4:0]  OPTIONS_RESET = 5'b00001;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        elapsed;
      logic [31:0]        now_time;
      logic [15:0]        msg_id;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        out_id;
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   // results still owed for one transaction, emitted in this order
   typedef struct packed {
      logic pub;
      logic loop;
      logic alarm;
   } pend_type;

   typedef struct packed {
      pend_type           pend;
      logic               alarm_raise;
      logic signed [31:0] value;
      logic [15:0]        point_id;
      logic [15:0]        alarm_msg;
   } job_type;

endpackage

>>> design/ppla_front.sv
// Front end: configuration registers, datapoint state, and classification
// of each accepted transaction into a result job. Depends on ppla_pkg.
`include "periodic_publish_with_limit_alarm_assert.svh"
module ppla_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cfg_we,
   input  logic [ppla_pkg::CSR_IDX_W-1:0] cfg_index,
   input  logic [31:0]                cfg_wdata,
   input  logic                       req_accept,
   input  ppla_pkg::req_type          req_data,
   output logic                       push,
   output ppla_pkg::job_type          job
);
   import ppla_pkg::*;

   logic [15:0]        point_id_ff;
   logic [15:0]        period_ff;
   logic [4:0]         options_ff;
   logic signed [31:0] limit_low_ff;
   logic signed [31:0] limit_high_ff;
   logic [15:0]        hold_ff;
   logic [15:0]        alarm_msg_ff;
   logic [15:0]        clear_id_ff;

   logic [15:0]        countdown_ff, countdown_in;
   logic [31:0]        exc_start_ff, exc_start_in;
   logic signed [31:0] stored_ff, stored_in;

   logic        is_tick, due, outside, ripe, raise, recv, lvl_clear, capture;
   logic [15:0] reload;
   logic [31:0] exc_open, exc_end;

   always_comb begin
      is_tick   = (req_data.mode == MODE_TICK) && (req_data.elapsed != 16'd0);
      due       = is_tick && options_ff[OPT_PUB] && (countdown_ff <= req_data.elapsed);
      reload    = due ? period_ff : countdown_ff;
      countdown_in = countdown_ff;
      if (is_tick) begin
         countdown_in = (reload < req_data.elapsed) ? 16'd0 : reload - req_data.elapsed;
      end

      outside = (options_ff[OPT_MAX] && (stored_ff > limit_high_ff)) ||
                (options_ff[OPT_MIN] && (stored_ff < limit_low_ff));
      // a zero start means no open excursion; one opening now takes now_time
      exc_open = (exc_start_ff == 32'd0) ? req_data.now_time : exc_start_ff;
      exc_end  = exc_open + {16'd0, hold_ff};
      ripe     = exc_end <= req_data.now_time;
      raise    = due && outside && ripe;

      recv      = (req_data.mode == MODE_RECV) && !options_ff[OPT_LOOP];
      lvl_clear = recv && !options_ff[OPT_EVENT] && (req_data.msg_id == clear_id_ff);

      priority if (due && outside) begin
         exc_start_in = raise ? 32'd0 : exc_open;
      end else if (lvl_clear) begin
         exc_start_in = 32'd0;
      end else begin
         exc_start_in = exc_start_ff;
      end

      capture = (req_data.msg_id == point_id_ff) &&
                ((req_data.mode == MODE_SET) || (recv && !options_ff[OPT_PUB]));
      stored_in = capture ? req_data.sample : stored_ff;

      job.pend.pub   = due;
      job.pend.loop  = due && options_ff[OPT_LOOP];
      job.pend.alarm = (due && (raise || options_ff[OPT_EVENT])) || lvl_clear;
      job.alarm_raise = raise;
      job.value      = stored_ff;
      job.point_id   = point_id_ff;
      job.alarm_msg  = alarm_msg_ff;
      push = req_accept && (job.pend.pub || job.pend.alarm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_id_ff   <= '0;
         period_ff     <= '0;
         options_ff    <= OPTIONS_RESET;
         limit_low_ff  <= '0;
         limit_high_ff <= '0;
         hold_ff       <= '0;
         alarm_msg_ff  <= '0;
         clear_id_ff   <= '0;
      end else if (cfg_we) begin
         unique case (cfg_index)
            CSR_POINT_ID:     point_id_ff   <= cfg_wdata[15:0];
            CSR_PERIOD:       period_ff     <= cfg_wdata[15:0];
            CSR_OPTIONS:      options_ff    <= cfg_wdata[4:0];
            CSR_LIMIT_LOW:    limit_low_ff  <= cfg_wdata;
            CSR_LIMIT_HIGH:   limit_high_ff <= cfg_wdata;
            CSR_HOLD_TICKS:   hold_ff       <= cfg_wdata[15:0];
            CSR_ALARM_MSG_ID: alarm_msg_ff  <= cfg_wdata[15:0];
            CSR_CLEAR_MSG_ID: clear_id_ff   <= cfg_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         exc_start_ff <= '0;
         stored_ff    <= '0;
      end else if (req_accept) begin
         countdown_ff <= countdown_in;
         exc_start_ff <= exc_start_in;
         stored_ff    <= stored_in;
      end
   end

   // a loopback copy is only ever owed together with the bus publish
   `PPLA_ASSERT(a_loop_needs_pub, clock, reset, !(push && job.pend.loop && !job.pend.pub))
   // set transactions never produce a job
   `PPLA_ASSERT(a_set_silent, clock, reset, !(push && (req_data.mode == MODE_SET)))

endmodule

>>> design/ppla_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on ppla_pkg for the job type.
`include "periodic_publish_with_limit_alarm_assert.svh"
module ppla_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppla_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              nonempty,
   output ppla_pkg::job_type head
);
   import ppla_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   job_type         slots_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      full     = count_ff == CW'(DEPTH);
      nonempty = count_ff != '0;
      head     = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   `PPLA_ASSERT(a_no_overflow, clock, reset, !(push && full))
   `PPLA_ASSERT(a_no_underflow, clock, reset, !(pop && !nonempty))

endmodule

>>> design/ppla_back.sv
// Result sequencer: takes jobs from the queue and delivers their results,
// one per cycle while rsp_stall is low, from registered state. Depends on ppla_pkg.
`include "periodic_publish_with_limit_alarm_assert.svh"
module ppla_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  ppla_pkg::job_type job_head,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppla_pkg::rsp_type rsp_data
);
   import ppla_pkg::*;

   pend_type pend_ff, pend_in, pend_rest;
   job_type  job_ff;
   logic     rsp_accept;

   always_comb begin
      rsp_valid  = pend_ff.pub || pend_ff.loop || pend_ff.alarm;
      rsp_accept = rsp_valid && !rsp_stall;

      pend_rest = pend_ff;
      priority if (pend_ff.pub) begin
         pend_rest.pub      = 1'b0;
         rsp_data.kind      = KIND_PUB;
         rsp_data.out_id    = job_ff.point_id;
         rsp_data.out_value = job_ff.value;
      end else if (pend_ff.loop) begin
         pend_rest.loop     = 1'b0;
         rsp_data.kind      = KIND_LOOP;
         rsp_data.out_id    = job_ff.point_id;
         rsp_data.out_value = job_ff.value;
      end else begin
         pend_rest.alarm    = 1'b0;
         rsp_data.kind      = KIND_ALARM;
         rsp_data.out_id    = job_ff.alarm_msg;
         rsp_data.out_value = {31'd0, job_ff.alarm_raise};
      end
      rsp_data.last = pend_rest == '0;

      // refill as soon as the current job has nothing left to show
      job_pop = job_ready && (!rsp_valid || (rsp_accept && rsp_data.last));
      pend_in = pend_ff;
      if (job_pop) begin
         pend_in = job_head.pend;
      end else if (rsp_accept) begin
         pend_in = pend_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_head;
      end
   end

   // every queued job carries at least one result
   `PPLA_ASSERT_NEXT(a_pop_shows, clock, reset, job_pop, rsp_valid)

endmodule

>>> design/periodic_publish_with_limit_alarm.sv
// Top level of the periodic publisher with limit alarm.
// Instantiates ppla_front, ppla_queue and ppla_back; depends on ppla_pkg.
//
// A request transaction is accepted in any cycle in which the job queue has
// room, and its effect on the stored value, publish countdown and excursion
// start is complete at that edge, so requests may follow back to back. Each
// request yields zero to three results (bus publish, loopback copy, alarm),
// delivered one per cycle while rsp_stall is low, from a registered output
// stage; all results share the response port, which therefore sets the
// sustained rate when results are dense. QUEUE_DEPTH jobs may wait between
// the two sides. Configuration writes are always ready and take effect at
// the next edge. A request's job is written into the job queue at the edge
// that accepts it and then loaded into the result sequencer's registers
// once the sequencer is free, before its first result appears.
module periodic_publish_with_limit_alarm #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ppla_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ppla_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ppla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import ppla_pkg::*;

   logic    q_full, q_nonempty, q_push, q_pop, req_accept;
   job_type push_job, head_job;

   assign csr_ready  = 1'b1;
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   ppla_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_we     (csr_valid && csr_ready),
      .cfg_index  (csr_index),
      .cfg_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_data   (req_data),
      .push       (q_push),
      .job        (push_job)
   );

   ppla_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .head     (head_job)
   );

   ppla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (q_nonempty),
      .job_head  (head_job),
      .job_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/periodic_publish_with_limit_alarm_tb.sv
// Self-checking testbench for periodic_publish_with_limit_alarm: directed and random request
// streams, CSR phases, random stalls on both channels and a long response hold-off.
// Depends on ppla_pkg and the periodic_publish_with_limit_alarm RTL.
`timescale 1ns / 100ps

module periodic_publish_with_limit_alarm_tb;
   import ppla_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [4:0] M_PUB   = 5'b1 << OPT_PUB;
   localparam logic [4:0] M_LOOP  = 5'b1 << OPT_LOOP;
   localparam logic [4:0] M_MIN   = 5'b1 << OPT_MIN;
   localparam logic [4:0] M_MAX   = 5'b1 << OPT_MAX;
   localparam logic [4:0] M_EVENT = 5'b1 << OPT_EVENT;
   localparam int SETTLE_CYCLES = 16;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   periodic_publish_with_limit_alarm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers
   logic [15:0]        cfg_point, cfg_period, cfg_hold, cfg_alarm_msg, cfg_clear_id;
   logic [4:0]         cfg_opts;
   logic signed [31:0] cfg_low, cfg_high;
   // predicted block state
   logic [15:0]        pub_countdown;
   logic [31:0]        excursion_t0;
   logic signed [31:0] held_value;

   req_type stim_q[$];
   rsp_type owed_messages[$];

   int fail_count = 0;
   int items_taken = 0;
   int msgs_checked = 0;
   int raises_seen = 0;
   int req_idle_pct = 11;
   int rsp_idle_pct = 11;
   int hold_len = 0;
   int hold_seq = 0;
   logic [31:0] tick_clock = 32'd1000;

   task automatic reset_shadow();
      cfg_point     = '0;
      cfg_period    = '0;
      cfg_opts      = OPTIONS_RESET;
      cfg_low       = '0;
      cfg_high      = '0;
      cfg_hold      = '0;
      cfg_alarm_msg = '0;
      cfg_clear_id  = '0;
      pub_countdown = '0;
      excursion_t0  = '0;
      held_value    = '0;
   endtask

   // opens an excursion if none is open, returns whether it has lasted long enough
   function automatic logic excursion_ripe(input logic [31:0] now);
      logic [31:0] due_at;
      if (excursion_t0 == 32'd0)
         excursion_t0 = now;
      due_at = excursion_t0 + {16'd0, cfg_hold};
      return due_at <= now;
   endfunction

   task automatic forecast_messages(input req_type r);
      rsp_type batch [3];
      int n;
      logic raise;
      n = 0;
      raise = 1'b0;
      case (r.mode)
         MODE_TICK: begin
            if (r.elapsed != 16'd0) begin
               if (cfg_opts[OPT_PUB] && pub_countdown <= r.elapsed) begin
                  pub_countdown = cfg_period;
                  batch[n] = '{KIND_PUB, cfg_point, held_value, 1'b0};
                  n++;
                  if (cfg_opts[OPT_LOOP]) begin
                     batch[n] = '{KIND_LOOP, cfg_point, held_value, 1'b0};
                     n++;
                  end
                  if (cfg_opts[OPT_MAX] && held_value > cfg_high)
                     raise = excursion_ripe(r.now_time);
                  if (!raise && cfg_opts[OPT_MIN] && held_value < cfg_low)
                     raise = excursion_ripe(r.now_time);
                  if (raise) begin
                     batch[n] = '{KIND_ALARM, cfg_alarm_msg, 32'sd1, 1'b0};
                     n++;
                     excursion_t0 = '0;
                  end else if (cfg_opts[OPT_EVENT]) begin
                     batch[n] = '{KIND_ALARM, cfg_alarm_msg, 32'sd0, 1'b0};
                     n++;
                  end
               end
               pub_countdown = (pub_countdown < r.elapsed) ? 16'd0 : pub_countdown - r.elapsed;
            end
         end
         MODE_SET: begin
            if (r.msg_id == cfg_point)
               held_value = r.sample;
         end
         MODE_RECV: begin
            if (!cfg_opts[OPT_LOOP]) begin
               if (!cfg_opts[OPT_EVENT] && r.msg_id == cfg_clear_id) begin
                  excursion_t0 = '0;
                  batch[n] = '{KIND_ALARM, cfg_alarm_msg, 32'sd0, 1'b0};
                  n++;
               end
               if (r.msg_id == cfg_point && !cfg_opts[OPT_PUB])
                  held_value = r.sample;
            end
         end
         default: ;
      endcase
      if (n > 0)
         batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         owed_messages.push_back(batch[i]);
   endtask

   // request driver: predicts each transaction at the edge it is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            forecast_messages(stim_q.pop_front());
            items_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= stim_q[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      int hold_left;
      int hold_seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_messages.size() == 0) begin
            $error("unexpected message kind %0d id %h value %h",
                   rsp_data.kind, rsp_data.out_id, rsp_data.out_value);
            fail_count++;
         end else begin
            want = owed_messages.pop_front();
            msgs_checked++;
            if (want.kind == KIND_ALARM && want.out_value == 32'sd1)
               raises_seen++;
            if (rsp_data.kind !== want.kind) begin
               $error("kind expected %0d actual %0d", want.kind, rsp_data.kind);
               fail_count++;
            end
            if (rsp_data.out_id !== want.out_id) begin
               $error("out_id expected %h actual %h", want.out_id, rsp_data.out_id);
               fail_count++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value expected %h actual %h", want.out_value, rsp_data.out_value);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [15:0] elapsed,
                            input logic [31:0] now, input logic [15:0] id,
                            input logic [31:0] sample);
      req_type r;
      r.mode     = mode;
      r.elapsed  = elapsed;
      r.now_time = now;
      r.msg_id   = id;
      r.sample   = sample;
      stim_q.push_back(r);
      while (stim_q.size() > 2)
         @(posedge clock);
   endtask

   // wait until all requests are taken and every owed message has come out
   task automatic settle();
      int guard;
      guard = 0;
      while (stim_q.size() != 0 || req_valid)
         @(posedge clock);
      while (owed_messages.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (owed_messages.size() != 0) begin
         $error("%0d expected messages never arrived", owed_messages.size());
         fail_count++;
         owed_messages.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_POINT_ID:     cfg_point     = data[15:0];
         CSR_PERIOD:       cfg_period    = data[15:0];
         CSR_OPTIONS:      cfg_opts      = data[4:0];
         CSR_LIMIT_LOW:    cfg_low       = data;
         CSR_LIMIT_HIGH:   cfg_high      = data;
         CSR_HOLD_TICKS:   cfg_hold      = data[15:0];
         CSR_ALARM_MSG_ID: cfg_alarm_msg = data[15:0];
         CSR_CLEAR_MSG_ID: cfg_clear_id  = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] point, input logic [15:0] period,
                            input logic [4:0] opts, input logic [31:0] low,
                            input logic [31:0] high, input logic [15:0] hold,
                            input logic [15:0] alarm_msg, input logic [15:0] clear_id);
      csr_write(CSR_POINT_ID, {16'd0, point});
      csr_write(CSR_PERIOD, {16'd0, period});
      csr_write(CSR_OPTIONS, {27'd0, opts});
      csr_write(CSR_LIMIT_LOW, low);
      csr_write(CSR_LIMIT_HIGH, high);
      csr_write(CSR_HOLD_TICKS, {16'd0, hold});
      csr_write(CSR_ALARM_MSG_ID, {16'd0, alarm_msg});
      csr_write(CSR_CLEAR_MSG_ID, {16'd0, clear_id});
   endtask

   // registers still at reset values: publish only, period 0
   task automatic test_reset_state();
      send_item(MODE_TICK, 16'd1, 32'd5, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd0, 32'd6, 16'hffff, 32'hffff_ffff);
      send_item(MODE_SPARE, 16'hffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
      send_item(MODE_SET, 16'd0, 32'd0, 16'd0, 32'h7fff_ffff);
      send_item(MODE_TICK, 16'hffff, 32'd7, 16'd0, 32'd0);
      settle();
   endtask

   task automatic test_publish_loopback();
      write_all(16'hffff, 16'd3, M_PUB | M_LOOP, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
      send_item(MODE_SET, 16'd0, 32'd0, 16'h1234, 32'd5);
      send_item(MODE_SET, 16'd0, 32'd0, 16'hffff, 32'h8000_0000);
      send_item(MODE_TICK, 16'd1, 32'd10, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd11, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd12, 16'd0, 32'd0);
      send_item(MODE_RECV, 16'd0, 32'd0, 16'hffff, 32'd1);   // dropped, loopback on
      settle();
   endtask

   task automatic test_limit_alarm();
      write_all(16'h0001, 16'd0, M_PUB | M_MIN | M_MAX, 32'hffff_0000, 32'h0001_0000,
                16'd5, 16'ha1a1, 16'h0c0c);
      send_item(MODE_SET, 16'd0, 32'd0, 16'h0001, 32'h0002_0000);
      // an excursion opened at time zero still reads as none
      send_item(MODE_TICK, 16'd1, 32'd0, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd100, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd105, 16'd0, 32'd0);
      send_item(MODE_SET, 16'd0, 32'd0, 16'h0001, 32'h8000_0000);
      send_item(MODE_TICK, 16'd1, 32'd200, 16'd0, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd205, 16'd0, 32'd0);
      settle();
      csr_write(CSR_OPTIONS, {27'd0, M_PUB | M_MIN | M_MAX | M_EVENT});
      send_item(MODE_SET, 16'd0, 32'd0, 16'h0001, 32'd0);
      send_item(MODE_TICK, 16'd1, 32'd300, 16'd0, 32'd0);
      settle();
   endtask

   task automatic test_recv_clear();
      csr_write(CSR_OPTIONS, 32'd0);
      send_item(MODE_RECV, 16'd0, 32'd0, 16'h0c0c, 32'd0);
      send_item(MODE_RECV, 16'd0, 32'd0, 16'h0001, 32'h1234_5678);
      settle();
      csr_write(CSR_OPTIONS, {27'd0, M_PUB | M_EVENT});
      send_item(MODE_RECV, 16'd0, 32'd0, 16'h0c0c, 32'd0);
      send_item(MODE_TICK, 16'd2, 32'd400, 16'd0, 32'd0);
      settle();
   endtask

   // every tick owes three messages; the response side holds off so the queue backs up
   task automatic test_backpressure();
      write_all(16'h0042, 16'd0, M_PUB | M_LOOP | M_EVENT, 32'd0, 32'd0, 16'd0,
                16'h0a1a, 16'h0c1c);
      hold_len = 300;
      hold_seq++;
      for (int i = 0; i < 40; i++) begin
         tick_clock = tick_clock + 32'd1;
         send_item(MODE_TICK, 16'd1, tick_clock, 16'($urandom), $urandom);
      end
      settle();
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(7))
         0: v = cfg_low - 32'd1;
         1: v = cfg_low;
         2: v = cfg_high;
         3: v = cfg_high + 32'd1;
         4: v = ($urandom_range(6) << 16) - 32'h0003_0000 + $urandom_range(16'hffff);
         7: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_id();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4)
         return cfg_point;
      if (sel < 7)
         return cfg_clear_id;
      return 16'($urandom);
   endfunction

   task automatic random_config();
      logic [15:0] period, hold;
      logic [4:0]  opts;
      logic [31:0] low, high;
      period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      hold   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
      opts   = 5'($urandom);
      if ($urandom_range(3) != 0)
         opts[OPT_PUB] = 1'b1;
      if ($urandom_range(4) == 0) begin
         low  = $urandom;
         high = $urandom;
      end else begin
         low  = 32'd0 - ($urandom_range(3) << 16);
         high = $urandom_range(3) << 16;
      end
      write_all(16'($urandom), period, opts, low, high, hold, 16'($urandom), 16'($urandom));
   endtask

   task automatic send_random_item();
      int sel;
      logic [15:0] el;
      logic [31:0] now;
      sel = $urandom_range(99);
      if (sel < 60) begin
         case ($urandom_range(19))
            0:       el = 16'd0;
            1, 2:    el = 16'($urandom);
            default: el = 16'($urandom_range(1, 4));
         endcase
         tick_clock = tick_clock + el;
         sel = $urandom_range(99);
         if (sel < 5)
            tick_clock = $urandom;
         now = (sel >= 5 && sel < 8) ? 32'd0 : tick_clock;
         send_item(MODE_TICK, el, now, 16'($urandom), $urandom);
      end else if (sel < 80) begin
         send_item(MODE_SET, 16'($urandom), $urandom,
                   ($urandom_range(4) != 0) ? cfg_point : 16'($urandom), pick_sample());
      end else if (sel < 95) begin
         send_item(MODE_RECV, 16'($urandom), $urandom, pick_id(), pick_sample());
      end else begin
         send_item(MODE_SPARE, 16'($urandom), $urandom, 16'($urandom), $urandom);
      end
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < 12; ph++) begin
         settle();
         req_idle_pct = (ph == 4) ? 0 : 11;
         rsp_idle_pct = (ph == 4) ? 0 : 11;
         case (ph)
            0: write_all(16'h0000, 16'h0000, 5'h00, 32'h8000_0000, 32'h8000_0000,
                         16'h0000, 16'h0000, 16'h0000);
            1: write_all(16'hffff, 16'hffff, 5'h1f, 32'h7fff_ffff, 32'h7fff_ffff,
                         16'hffff, 16'hffff, 16'hffff);
            2: write_all(16'h5a5a, 16'h0001, M_PUB | M_MIN | M_MAX, 32'h7fff_ffff,
                         32'h8000_0000, 16'h0000, 16'ha5a5, 16'h5a5b);
            default: random_config();
         endcase
         for (int k = 0; k < 35; k++)
            send_random_item();
      end
      req_idle_pct = 11;
      rsp_idle_pct = 11;
      settle();
   endtask

   initial begin
      reset_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_reset_state();
      test_publish_loopback();
      test_limit_alarm();
      test_recv_clear();
      test_backpressure();
      test_random_traffic();
      $display("covered %0d requests across many register settings, with a 300-cycle hold-off",
               items_taken);
      $display("checked %0d messages, %0d of them alarm raises", msgs_checked, raises_seen);
      if (fail_count == 0)
         $display("periodic_publish_with_limit_alarm_tb passed");
      else
         $display("periodic_publish_with_limit_alarm_tb failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d messages outstanding", owed_messages.size());
      $display("periodic_publish_with_limit_alarm_tb failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/ppla_pkg.sv
design/ppla_front.sv
design/ppla_queue.sv
design/ppla_back.sv
design/periodic_publish_with_limit_alarm.sv
dv/periodic_publish_with_limit_alarm_tb.sv
